// ===== design/bxt_pkg.sv =====
// Shared types and constants for the binary trie maximum-xor block.
package bxt_pkg;

  // Trie geometry.
  localparam int NODE_COUNT = 4096;
  localparam int KEY_BITS   = 32;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int USED_W     = $clog2(NODE_COUNT + 1);
  localparam int LVL_W      = $clog2(KEY_BITS);
  localparam int ENTRY_W    = 2 * IDX_W;

  // Result field widths.
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Input item modes.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // One node: child for bit 1 in the upper half, child for bit 0 in the lower half.
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // Request bundle from the walker to the node memory.
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    logic   re;
    idx_t   raddr;
  } mem_req_t;

endpackage

// ===== design/bxt_if.sv =====
// Handshake channels for the input items and the result items.
interface bxt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [bxt_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface bxt_out_if;
  logic                         valid;
  logic                         ready;
  logic [bxt_pkg::VALUE_W-1:0]  max_xor;
  logic [bxt_pkg::STATUS_W-1:0] status;

  modport source (output valid, output max_xor, output status, input ready);
  modport sink   (input valid, input max_xor, input status, output ready);
endinterface

// ===== design/binary_trie_max_xor_top.sv =====
// Top level of the binary trie maximum-xor block: trie walker and result register.
//
//   channel | direction | fields          | handshake
//   in_ch   | input     | mode, value     | valid / ready
//   out_ch  | output    | max_xor, status | valid / ready
//
// One item is in work at a time. A query is accepted, reads the trie one level at a
// time (up to 32 levels) and then enters its result state; a query on an empty trie
// skips the walk. An insert reads levels until the first missing child, then links the
// first new node and writes the new nodes one after another. A duplicate or rejected
// insert goes from the walk straight to its result state.
// The node store has a single read port and a single write port.
// Reset needs no clearing pass: the root reads as empty until its first write.
// A result waits in the output register; the walker holds in its result state while
// that register is still full.
module binary_trie_max_xor_top (
  input  logic clk,
  input  logic rst_n,
  bxt_in_if.sink    in_ch,
  bxt_out_if.source out_ch
);
  import bxt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LINK,
    S_FILL,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic                   mode_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [LVL_W-1:0]       lvl_r;
  idx_t                   cur_r;
  entry_t                 ent_r;
  logic [KEY_BITS-1:0]    acc_r;
  logic                   first_r;
  logic                   root_wr_r;
  logic [USED_W-1:0]      nodes_used_r;
  logic [VALUE_W-1:0]     res_r;
  logic [STATUS_W-1:0]    st_r;
  logic                   out_valid_r;
  logic [VALUE_W-1:0]     out_max_r;
  logic [STATUS_W-1:0]    out_st_r;

  mem_req_t               req;
  entry_t                 node_q;
  entry_t                 ent;
  idx_t                   child0;
  idx_t                   child1;
  logic                   kbit;
  idx_t                   ins_nxt;
  idx_t                   q_pref;
  idx_t                   q_alt;
  logic [USED_W-1:0]      missing;
  logic [USED_W-1:0]      room;
  logic [LVL_W-1:0]       lvl_dn;
  logic [KEY_BITS-1:0]    acc_set;
  logic                   in_fire;
  logic                   trie_empty;
  logic                   out_free;
  idx_t                   fresh;
  entry_t                 link_ent;
  entry_t                 fill_ent;

  bxt_node_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (node_q)
  );

  // Handshake and status terms.
  assign in_ch.ready    = (state_r == S_IDLE);
  assign in_fire        = in_ch.valid && in_ch.ready;
  assign trie_empty     = (nodes_used_r <= USED_W'(1));
  assign out_free       = !out_valid_r || out_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.max_xor = out_max_r;
  assign out_ch.status  = out_st_r;

  // Node just read; the root reads as empty until it has been written once.
  assign ent    = (first_r && !root_wr_r) ? '0 : node_q;
  assign child0 = ent[IDX_W-1:0];
  assign child1 = ent[ENTRY_W-1:IDX_W];
  assign kbit   = key_r[lvl_r];
  assign lvl_dn = lvl_r - LVL_W'(1);

  // Insert follows the key bit; query prefers the opposite bit.
  assign ins_nxt = kbit ? child1 : child0;
  assign q_pref  = kbit ? child0 : child1;
  assign q_alt   = kbit ? child1 : child0;
  assign acc_set = acc_r | (KEY_BITS'(1) << lvl_r);

  // Nodes still needed by an insert against the nodes left.
  assign missing = USED_W'(lvl_r) + USED_W'(1);
  assign room    = USED_W'(NODE_COUNT) - nodes_used_r;

  // Entries written while a new path is built.
  assign fresh = nodes_used_r[IDX_W-1:0];
  always_comb begin
    link_ent = ent_r;
    if (kbit) begin
      link_ent[ENTRY_W-1:IDX_W] = fresh;
    end else begin
      link_ent[IDX_W-1:0] = fresh;
    end
    fill_ent = '0;
    if (lvl_r != '0) begin
      if (key_r[lvl_dn]) begin
        fill_ent[ENTRY_W-1:IDX_W] = fresh + IDX_W'(1);
      end else begin
        fill_ent[IDX_W-1:0] = fresh + IDX_W'(1);
      end
    end
  end

  // Memory requests: reads on acceptance and during the walk, writes while linking and filling.
  always_comb begin
    req       = '0;
    req.raddr = '0;
    case (state_r)
      S_IDLE: begin
        req.re = in_fire && !(in_ch.mode == MODE_QUERY && trie_empty);
      end
      S_WALK: begin
        if (mode_r == MODE_INSERT) begin
          req.re    = (ins_nxt != '0) && (lvl_r != '0);
          req.raddr = ins_nxt;
        end else begin
          req.re    = (lvl_r != '0) && ((q_pref != '0) || (q_alt != '0));
          req.raddr = (q_pref != '0) ? q_pref : q_alt;
        end
      end
      S_LINK: begin
        req.we    = 1'b1;
        req.waddr = cur_r;
        req.wdata = link_ent;
      end
      S_FILL: begin
        req.we    = 1'b1;
        req.waddr = fresh;
        req.wdata = fill_ent;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  // Walker state machine and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      root_wr_r    <= 1'b0;
      nodes_used_r <= USED_W'(1);
      out_valid_r  <= 1'b0;
      first_r      <= 1'b0;
    end else begin
      // The result register empties here unless the result state reloads it.
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            mode_r  <= in_ch.mode;
            key_r   <= in_ch.value[KEY_BITS-1:0];
            lvl_r   <= LVL_W'(KEY_BITS - 1);
            cur_r   <= '0;
            acc_r   <= '0;
            first_r <= 1'b1;
            if (in_ch.mode == MODE_QUERY && trie_empty) begin
              res_r   <= '0;
              st_r    <= ST_EMPTY;
              state_r <= S_DONE;
            end else begin
              state_r <= S_WALK;
            end
          end
        end
        S_WALK: begin
          first_r <= 1'b0;
          if (mode_r == MODE_INSERT) begin
            if (ins_nxt != '0) begin
              if (lvl_r == '0) begin
                res_r   <= '0;
                st_r    <= ST_OK;
                state_r <= S_DONE;
              end else begin
                cur_r <= ins_nxt;
                lvl_r <= lvl_dn;
              end
            end else if (missing > room) begin
              res_r   <= '0;
              st_r    <= ST_FULL;
              state_r <= S_DONE;
            end else begin
              ent_r   <= ent;
              state_r <= S_LINK;
            end
          end else begin
            // Query: take the opposite child when present, else the same one.
            if (q_pref != '0) begin
              acc_r <= acc_set;
              cur_r <= q_pref;
            end else if (q_alt != '0) begin
              cur_r <= q_alt;
            end
            if (q_pref == '0 && q_alt == '0) begin
              res_r   <= VALUE_W'(acc_r);
              st_r    <= ST_OK;
              state_r <= S_DONE;
            end else if (lvl_r == '0) begin
              res_r   <= VALUE_W'((q_pref != '0) ? acc_set : acc_r);
              st_r    <= ST_OK;
              state_r <= S_DONE;
            end else begin
              lvl_r <= lvl_dn;
            end
          end
        end
        S_LINK: begin
          if (cur_r == '0) begin
            root_wr_r <= 1'b1;
          end
          state_r <= S_FILL;
        end
        S_FILL: begin
          nodes_used_r <= nodes_used_r + USED_W'(1);
          if (lvl_r == '0) begin
            res_r   <= '0;
            st_r    <= ST_OK;
            state_r <= S_DONE;
          end else begin
            lvl_r <= lvl_dn;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_max_r   <= res_r;
            out_st_r    <= st_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The node count stays between the root alone and the full store.
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nodes_used_r >= USED_W'(1)) && (nodes_used_r <= USED_W'(NODE_COUNT)))
    else $error("node count out of range");

  // The store is never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.we && req.re))
    else $error("node store read and write overlap");

  // A new node is written only at the next free entry.
  a_fill_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (req.waddr == fresh) && (nodes_used_r < USED_W'(NODE_COUNT)))
    else $error("node allocated beyond the free entry");

  // Only a good query carries a nonzero result.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != ST_OK) |-> (out_max_r == '0))
    else $error("error result with nonzero max_xor");

  // An accepted item leaves the idle state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("walker idle right after accepting an item");

endmodule

// ===== design/bxt_node_mem.sv =====
// Node store: one write port and one registered read port.
module bxt_node_mem (
  input  logic              clk,
  input  bxt_pkg::mem_req_t req,
  output bxt_pkg::entry_t   rd_data
);
  import bxt_pkg::*;

  entry_t mem [NODE_COUNT];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ===== tb/binary_trie_max_xor_top_tb.sv =====
// Testbench for the binary trie maximum-xor block: random and directed items checked in order.
module binary_trie_max_xor_top_tb;
  import bxt_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RANDOM_ITEMS   = 900;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_RESULT = 650;
  localparam int DRAIN_CYCLES   = 100;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int MAX_REPORTS    = 50;

  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] value;
  } trie_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  max_xor;
    logic [STATUS_W-1:0] status;
  } trie_answer_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               drv_valid = 1'b0;
  logic               drv_mode  = MODE_INSERT;
  logic [VALUE_W-1:0] drv_value = '0;
  logic               rx_ready  = 1'b0;
  logic               rx_hold   = 1'b0;
  logic               in_fire   = 1'b0;

  trie_op_t           trie_ops[$];
  trie_answer_t       trie_answers[$];
  logic [VALUE_W-1:0] planned_keys[$];

  // Private copy of the trie: two child indices per node.
  idx_t trie_kid [NODE_COUNT][2];
  int   trie_used;

  int n_in      = 0;
  int n_results = 0;
  int n_err     = 0;
  int n_total   = 0;

  bxt_in_if  in_ch ();
  bxt_out_if out_ch ();

  assign in_ch.valid  = drv_valid;
  assign in_ch.mode   = drv_mode;
  assign in_ch.value  = drv_value;
  assign out_ch.ready = rx_ready;

  binary_trie_max_xor_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // Walk the private trie for one item and return the answer it should give.
  function automatic trie_answer_t trie_answer(logic mode, logic [VALUE_W-1:0] value);
    trie_answer_t ans;
    int           cur;
    int           pos;
    int           missing;
    int           fresh;
    logic         want;
    ans.max_xor = '0;
    ans.status  = ST_OK;
    cur         = 0;
    if (mode == MODE_INSERT) begin
      // Follow the part of the path that already exists.
      pos = KEY_BITS - 1;
      while (pos >= 0 && trie_kid[cur][value[pos]] != '0) begin
        cur = trie_kid[cur][value[pos]];
        pos--;
      end
      missing = pos + 1;
      // A path that does not fit leaves the trie untouched.
      if (missing > NODE_COUNT - trie_used) begin
        ans.status = ST_FULL;
      end else begin
        for (; pos >= 0; pos--) begin
          fresh = trie_used;
          trie_used++;
          trie_kid[fresh][0]         = '0;
          trie_kid[fresh][1]         = '0;
          trie_kid[cur][value[pos]] = idx_t'(fresh);
          cur = fresh;
        end
      end
    end else if (trie_used <= 1) begin
      ans.status = ST_EMPTY;
    end else begin
      // Prefer the child opposite the query bit at every level.
      for (pos = KEY_BITS - 1; pos >= 0; pos--) begin
        want = ~value[pos];
        if (trie_kid[cur][want] != '0) begin
          ans.max_xor[pos] = 1'b1;
          cur = trie_kid[cur][want];
        end else if (trie_kid[cur][~want] != '0) begin
          cur = trie_kid[cur][~want];
        end else begin
          break;
        end
      end
    end
    return ans;
  endfunction

  task automatic report_mismatch(string msg);
    n_err++;
    if (n_err <= MAX_REPORTS) begin
      $display("mismatch at result %0d: %s", n_results, msg);
    end
  endtask

  function automatic void add_op(logic mode, logic [VALUE_W-1:0] value);
    trie_op_t op;
    op.mode  = mode;
    op.value = value;
    trie_ops.push_back(op);
    if (mode == MODE_INSERT) begin
      planned_keys.push_back(value);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] pick_key();
    return planned_keys[$urandom_range(0, planned_keys.size() - 1)];
  endfunction

  // Idle rates per phase: sender light / receiver heavy, then swapped, then none.
  function automatic bit idle_now(bit is_sender);
    int pct;
    if (n_in < 300) begin
      pct = is_sender ? 19 : 71;
    end else if (n_in < 600) begin
      pct = is_sender ? 71 : 19;
    end else begin
      pct = 0;
    end
    return $urandom_range(0, 99) < pct;
  endfunction

  // Present the next pending item once the current one has been taken.
  always @(negedge clk) begin : drive_items
    trie_op_t op;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_fire) begin
      if (trie_ops.size() != 0 && !idle_now(1'b1)) begin
        op = trie_ops.pop_front();
        drv_valid <= 1'b1;
        drv_mode  <= op.mode;
        drv_value <= op.value;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Result side ready, with random stalls and the long hold-off.
  always @(negedge clk) begin
    rx_ready <= rst_n && !rx_hold && !idle_now(1'b0);
  end

  // Predict on every accepted input item and check every accepted result item.
  always @(posedge clk) begin : watch_items
    trie_answer_t want;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      trie_answers.push_back(trie_answer(in_ch.mode, in_ch.value));
      n_in++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (trie_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected item max_xor %h status %0d",
                                  out_ch.max_xor, out_ch.status));
      end else begin
        want = trie_answers.pop_front();
        if (out_ch.max_xor !== want.max_xor) begin
          report_mismatch($sformatf("max_xor %h, expected %h", out_ch.max_xor, want.max_xor));
        end
        if (out_ch.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, want.status));
        end
      end
      n_results++;
    end
  end

  // Hold the result side off long enough that the block backs up into its input.
  initial begin
    wait (n_results >= HOLD_AT_RESULT);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Build the item list, release reset and wait for the block to drain.
  initial begin : stimulus
    int                 sel;
    int                 k;
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] mask;
    for (int i = 0; i < NODE_COUNT; i++) begin
      trie_kid[i][0] = '0;
      trie_kid[i][1] = '0;
    end
    trie_used = 1;

    // Directed items: empty trie, extreme keys, duplicates and extreme queries.
    add_op(MODE_QUERY,  32'h0000_0000);
    add_op(MODE_QUERY,  32'hFFFF_FFFF);
    add_op(MODE_INSERT, 32'h0000_0000);
    add_op(MODE_QUERY,  32'h0000_0000);
    add_op(MODE_QUERY,  32'hFFFF_FFFF);
    add_op(MODE_INSERT, 32'h0000_0000);
    add_op(MODE_INSERT, 32'hFFFF_FFFF);
    add_op(MODE_QUERY,  32'h0000_0000);
    add_op(MODE_QUERY,  32'h8000_0000);
    add_op(MODE_INSERT, 32'h8000_0000);
    add_op(MODE_INSERT, 32'h7FFF_FFFF);
    add_op(MODE_INSERT, 32'h0000_0001);
    add_op(MODE_QUERY,  32'h5555_5555);
    add_op(MODE_QUERY,  32'hAAAA_AAAA);
    add_op(MODE_QUERY,  32'h7FFF_FFFF);
    add_op(MODE_QUERY,  32'h0000_0001);
    add_op(MODE_INSERT, 32'hFFFF_FFFE);
    add_op(MODE_QUERY,  32'hFFFF_FFFE);
    add_op(MODE_INSERT, 32'hFFFF_FFFF);
    add_op(MODE_QUERY,  32'h8000_0001);

    // Random items: fresh keys fill the store, near keys share long prefixes.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < 45) begin
        if (sel < 4) begin
          v = $urandom;
        end else if (sel < 8) begin
          k    = $urandom_range(1, 12);
          mask = (32'h1 << k) - 32'h1;
          v    = (pick_key() & ~mask) | ($urandom & mask);
        end else begin
          v = pick_key();
        end
        add_op(MODE_INSERT, v);
      end else begin
        if (sel < 5) begin
          v = $urandom;
        end else if (sel < 8) begin
          v = pick_key() ^ ($urandom & 32'h0000_00FF);
        end else begin
          v = ~pick_key();
        end
        add_op(MODE_QUERY, v);
      end
    end
    n_total = trie_ops.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_in < n_total) @(posedge clk);
    while (trie_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bxt_pkg.sv
design/bxt_if.sv
design/bxt_node_mem.sv
design/binary_trie_max_xor_top.sv
tb/binary_trie_max_xor_top_tb.sv
